/* rtl/hic_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hard-iron calibrator package
// Shared widths, register defaults, register indexes and the result record
// passed from the tracking stage to the scaling stage.
// ----------------------------------------------------------------------------
package hic_pkg;

    localparam int SAMPLE_BITS_DEF = 13;

    localparam int GAIN_W      = 11;
    localparam int TURN_W      = 8;
    localparam int COUNT_W     = 16;
    localparam int OFFSET_W    = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int OFFSET_SHIFT = 9;

    localparam logic [GAIN_W-1:0]  GAIN_RESET   = GAIN_W'(236);
    localparam logic [TURN_W-1:0]  LIMIT_RESET  = TURN_W'(5);
    localparam logic [COUNT_W-1:0] TIMEOUT_RESET = COUNT_W'(300);

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_GAIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_LIMIT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_SAMPLES = 2'd2;

    localparam logic MODE_RESTART = 1'b0;

    typedef struct packed {
        logic              done;
        logic              timed_out;
        logic [TURN_W-1:0] turns;
    } hic_res_t;

endpackage

/* rtl/hic_square.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Squared magnitude stage
// Registers the sample with its squared horizontal magnitude X*X + Y*Y.
// ----------------------------------------------------------------------------
module hic_square #(
    parameter int SAMPLE_BITS = hic_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_mode,
    input  logic signed [SAMPLE_BITS-1:0] in_x,
    input  logic signed [SAMPLE_BITS-1:0] in_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_mode,
    output logic signed [SAMPLE_BITS-1:0] out_x,
    output logic signed [SAMPLE_BITS-1:0] out_y,
    output logic [2*SAMPLE_BITS-1:0]      out_mag
);
    import hic_pkg::*;

    logic                          valid_reg;
    logic                          mode_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic [2*SAMPLE_BITS-1:0]      mag_reg;
    logic signed [2*SAMPLE_BITS-1:0] sq_x;
    logic signed [2*SAMPLE_BITS-1:0] sq_y;
    logic [2*SAMPLE_BITS-1:0]      mag_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        sq_x     = in_x * in_x;
        sq_y     = in_y * in_y;
        mag_next = unsigned'(sq_x) + unsigned'(sq_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mode_reg <= in_mode;
            x_reg    <= in_x;
            y_reg    <= in_y;
            mag_reg  <= mag_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_mode  = mode_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_mag   = mag_reg;

endmodule

/* rtl/hic_track.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Run tracking stage
// Holds the run state: previous, strongest and weakest magnitude with their
// points, direction, turn and sample counters. Updates it once per beat and
// registers the status and the X/Y spans of the run.
// ----------------------------------------------------------------------------
module hic_track #(
    parameter int SAMPLE_BITS = hic_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [hic_pkg::TURN_W-1:0]      turn_limit,
    input  logic [hic_pkg::COUNT_W-1:0]     timeout_samples,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            in_mode,
    input  logic signed [SAMPLE_BITS-1:0]   in_x,
    input  logic signed [SAMPLE_BITS-1:0]   in_y,
    input  logic [2*SAMPLE_BITS-1:0]        in_mag,
    output logic                            out_valid,
    input  logic                            out_ready,
    output hic_pkg::hic_res_t               out_res,
    output logic signed [SAMPLE_BITS:0]     out_span_x,
    output logic signed [SAMPLE_BITS:0]     out_span_y
);
    import hic_pkg::*;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_RUN,
        RS_DONE_TURNS,
        RS_DONE_TIME
    } run_state_t;

    run_state_t                    state_reg, state_next;
    logic [2*SAMPLE_BITS-1:0]      prev_reg, prev_next;
    logic [2*SAMPLE_BITS-1:0]      max_reg, max_next;
    logic [2*SAMPLE_BITS-1:0]      min_reg, min_next;
    logic signed [SAMPLE_BITS-1:0] maxx_reg, maxx_next;
    logic signed [SAMPLE_BITS-1:0] maxy_reg, maxy_next;
    logic signed [SAMPLE_BITS-1:0] minx_reg, minx_next;
    logic signed [SAMPLE_BITS-1:0] miny_reg, miny_next;
    logic                          rising_reg, rising_next;
    logic [TURN_W-1:0]             turns_reg, turns_next;
    logic [COUNT_W-1:0]            count_reg, count_next;
    logic                          valid_reg;
    hic_res_t                      res_reg, res_next;
    logic signed [SAMPLE_BITS:0]   span_x_reg, span_x_next;
    logic signed [SAMPLE_BITS:0]   span_y_reg, span_y_next;
    logic                          up;
    logic                          load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_ready && in_valid;
    assign up       = in_mag > prev_reg;

    always_comb
    begin
        state_next  = state_reg;
        prev_next   = prev_reg;
        max_next    = max_reg;
        min_next    = min_reg;
        maxx_next   = maxx_reg;
        maxy_next   = maxy_reg;
        minx_next   = minx_reg;
        miny_next   = miny_reg;
        rising_next = rising_reg;
        turns_next  = turns_reg;
        count_next  = count_reg;

        if (in_mode == MODE_RESTART)
        begin
            state_next  = RS_RUN;
            prev_next   = in_mag;
            max_next    = in_mag;
            min_next    = in_mag;
            maxx_next   = in_x;
            maxy_next   = in_y;
            minx_next   = in_x;
            miny_next   = in_y;
            rising_next = 1'b0;
            turns_next  = '0;
            count_next  = '0;
        end
        else if (state_reg == RS_RUN)
        begin
            if ((up != rising_reg) && (turns_reg != '1))
            begin
                turns_next = turns_reg + 1'b1;
            end
            rising_next = up;
            prev_next   = in_mag;
            if (in_mag > max_reg)
            begin
                max_next  = in_mag;
                maxx_next = in_x;
                maxy_next = in_y;
            end
            if (in_mag < min_reg)
            begin
                min_next  = in_mag;
                minx_next = in_x;
                miny_next = in_y;
            end
            if (count_reg != '1)
            begin
                count_next = count_reg + 1'b1;
            end
            if (turns_next >= turn_limit)
            begin
                state_next = RS_DONE_TURNS;
            end
            else if (count_next >= timeout_samples)
            begin
                state_next = RS_DONE_TIME;
            end
        end

        res_next.done      = (state_next == RS_DONE_TURNS) || (state_next == RS_DONE_TIME);
        res_next.timed_out = (state_next == RS_DONE_TIME);
        res_next.turns     = turns_next;
        span_x_next = (SAMPLE_BITS+1)'(maxx_next) - (SAMPLE_BITS+1)'(minx_next);
        span_y_next = (SAMPLE_BITS+1)'(maxy_next) - (SAMPLE_BITS+1)'(miny_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= RS_IDLE;
            prev_reg   <= '0;
            max_reg    <= '0;
            min_reg    <= '0;
            maxx_reg   <= '0;
            maxy_reg   <= '0;
            minx_reg   <= '0;
            miny_reg   <= '0;
            rising_reg <= 1'b0;
            turns_reg  <= '0;
            count_reg  <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (load)
            begin
                state_reg  <= state_next;
                prev_reg   <= prev_next;
                max_reg    <= max_next;
                min_reg    <= min_next;
                maxx_reg   <= maxx_next;
                maxy_reg   <= maxy_next;
                minx_reg   <= minx_next;
                miny_reg   <= miny_next;
                rising_reg <= rising_next;
                turns_reg  <= turns_next;
                count_reg  <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg    <= res_next;
            span_x_reg <= span_x_next;
            span_y_reg <= span_y_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_res    = res_reg;
    assign out_span_x = span_x_reg;
    assign out_span_y = span_y_reg;

endmodule

/* rtl/hic_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Offset scaling stage
// Multiplies each span by the Q3.8 gain, takes the floor of half of it in
// Q.8, saturates to 16 bits (zero unless done), holds the result for output.
// ----------------------------------------------------------------------------
module hic_scale #(
    parameter int SAMPLE_BITS = hic_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [hic_pkg::GAIN_W-1:0]        scale_gain,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  hic_pkg::hic_res_t                 in_res,
    input  logic signed [SAMPLE_BITS:0]       in_span_x,
    input  logic signed [SAMPLE_BITS:0]       in_span_y,
    output logic                              out_valid,
    input  logic                              out_ready,
    output hic_pkg::hic_res_t                 out_res,
    output logic signed [hic_pkg::OFFSET_W-1:0] out_offset_x,
    output logic signed [hic_pkg::OFFSET_W-1:0] out_offset_y
);
    import hic_pkg::*;

    localparam int PW = SAMPLE_BITS + 1 + GAIN_W;
    localparam logic signed [PW-1:0] SAT_HI = PW'(32767);
    localparam logic signed [PW-1:0] SAT_LO = -PW'(32768);

    logic                       valid_reg;
    hic_res_t                   res_reg;
    logic signed [OFFSET_W-1:0] offx_reg, offx_next;
    logic signed [OFFSET_W-1:0] offy_reg, offy_next;

    function automatic logic signed [OFFSET_W-1:0] scale_sat(
        input logic signed [SAMPLE_BITS:0] span,
        input logic [GAIN_W-1:0]           gain
    );
        logic signed [PW-1:0] prod;
        logic signed [PW-1:0] q;
        prod = PW'(span) * PW'($signed({1'b0, gain}));
        q    = prod >>> OFFSET_SHIFT;
        if (q > SAT_HI)
        begin
            return OFFSET_W'(SAT_HI);
        end
        else if (q < SAT_LO)
        begin
            return OFFSET_W'(SAT_LO);
        end
        return OFFSET_W'(q);
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        offx_next = '0;
        offy_next = '0;
        if (in_res.done)
        begin
            offx_next = scale_sat(in_span_x, scale_gain);
            offy_next = scale_sat(in_span_y, scale_gain);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            res_reg  <= in_res;
            offx_reg <= offx_next;
            offy_reg <= offy_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_res      = res_reg;
    assign out_offset_x = offx_reg;
    assign out_offset_y = offy_reg;

endmodule

/* rtl/hard_iron_offset_calibrator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hard-iron offset calibrator
// Registered path of a beat: input register, squaring, run tracking, gain
// scaling. Throughput: one beat per cycle while m_tready is high; each stage
// holds when the stage after it is full, so bubbles are absorbed.
// Reset clears all run state to idle and loads the register defaults.
// ----------------------------------------------------------------------------
module hard_iron_offset_calibrator #(
    parameter int SAMPLE_BITS = hic_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hic_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hic_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: sample_x, sample_y, zero fill.
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,
    // Fields: mode.
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: offset_x, offset_y, turns_seen.
    output logic [39:0]                         m_tdata,
    // Fields: timed_out.
    output logic                                m_tuser,
    output logic                                m_tlast
);
    import hic_pkg::*;

    logic [GAIN_W-1:0]             gain_reg;
    logic [TURN_W-1:0]             limit_reg;
    logic [COUNT_W-1:0]            timeout_reg;

    logic                          a_valid_reg;
    logic                          a_mode_reg;
    logic signed [SAMPLE_BITS-1:0] a_x_reg;
    logic signed [SAMPLE_BITS-1:0] a_y_reg;

    logic                          b_ready;
    logic                          b_valid;
    logic                          b_mode;
    logic signed [SAMPLE_BITS-1:0] b_x;
    logic signed [SAMPLE_BITS-1:0] b_y;
    logic [2*SAMPLE_BITS-1:0]      b_mag;

    logic                          c_ready;
    logic                          c_valid;
    hic_res_t                      c_res;
    logic signed [SAMPLE_BITS:0]   c_span_x;
    logic signed [SAMPLE_BITS:0]   c_span_y;

    logic                          d_ready;
    hic_res_t                      d_res;
    logic signed [OFFSET_W-1:0]    d_offx;
    logic signed [OFFSET_W-1:0]    d_offy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= GAIN_RESET;
            limit_reg   <= LIMIT_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCALE_GAIN:      gain_reg    <= cfg_wdata[GAIN_W-1:0];
                CFG_TURN_LIMIT:      limit_reg   <= cfg_wdata[TURN_W-1:0];
                CFG_TIMEOUT_SAMPLES: timeout_reg <= cfg_wdata[COUNT_W-1:0];
                default:             ;
            endcase
        end
    end

    assign s_tready = !a_valid_reg || b_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            a_mode_reg <= s_tuser;
            a_x_reg    <= s_tdata[SAMPLE_BITS-1:0];
            a_y_reg    <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
    end

    hic_square #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_valid_reg),
        .in_ready  (b_ready),
        .in_mode   (a_mode_reg),
        .in_x      (a_x_reg),
        .in_y      (a_y_reg),
        .out_valid (b_valid),
        .out_ready (c_ready),
        .out_mode  (b_mode),
        .out_x     (b_x),
        .out_y     (b_y),
        .out_mag   (b_mag)
    );

    hic_track #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_track (
        .clk             (clk),
        .rst_n           (rst_n),
        .turn_limit      (limit_reg),
        .timeout_samples (timeout_reg),
        .in_valid        (b_valid),
        .in_ready        (c_ready),
        .in_mode         (b_mode),
        .in_x            (b_x),
        .in_y            (b_y),
        .in_mag          (b_mag),
        .out_valid       (c_valid),
        .out_ready       (d_ready),
        .out_res         (c_res),
        .out_span_x      (c_span_x),
        .out_span_y      (c_span_y)
    );

    hic_scale #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .scale_gain   (gain_reg),
        .in_valid     (c_valid),
        .in_ready     (d_ready),
        .in_res       (c_res),
        .in_span_x    (c_span_x),
        .in_span_y    (c_span_y),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_res      (d_res),
        .out_offset_x (d_offx),
        .out_offset_y (d_offy)
    );

    assign m_tdata = {d_res.turns, d_offy, d_offx};
    assign m_tuser = d_res.timed_out;
    assign m_tlast = d_res.done;

endmodule
